FILE: hdl/fmenv_pkg.sv
// shared types, constants and coefficient table for the fm operator envelope
// no dependencies; every other file in hdl imports this package
package fmenv_pkg;

    localparam int DB_FRAC_BITS  = 16;
    localparam int AMP_FRAC_BITS = 15;

    // field widths
    localparam int ATT_W    = DB_FRAC_BITS + 7;
    localparam int STATIC_W = DB_FRAC_BITS + 8;
    localparam int TOT_W    = DB_FRAC_BITS + 9;
    localparam int AMP_W    = AMP_FRAC_BITS + 1;
    localparam int COEF_W   = 17;
    localparam int STAGE_W  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = STATIC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY1_STEP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY1_LEVEL = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY2_STEP  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_ATT   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_AM_ENABLE    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_GRIT_MODE    = CFG_IDX_W'(7);

    // envelope stage codes as seen on env_stage
    localparam logic [STAGE_W-1:0] ENV_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] ENV_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] ENV_DECAY1  = 3'd2;
    localparam logic [STAGE_W-1:0] ENV_DECAY2  = 3'd3;
    localparam logic [STAGE_W-1:0] ENV_HOLD    = 3'd4;
    localparam logic [STAGE_W-1:0] ENV_RELEASE = 3'd5;

    // dB constants
    localparam logic [ATT_W-1:0]    SILENT_DB = ATT_W'(96 * (1 << DB_FRAC_BITS));
    localparam logic [STATIC_W-1:0] LIVE_LIMIT_DB = STATIC_W'(90 * (1 << DB_FRAC_BITS));
    localparam logic [ATT_W-1:0]    SNAP_DB = ATT_W'(((1 << DB_FRAC_BITS) + 5) / 10);
    localparam logic [COEF_W-1:0]   COEF_ONE = COEF_W'(65536);

    // grit step is 3 * 2^(DB_FRAC_BITS-5); quotient by 3 via reciprocal
    localparam int GRIT_SHIFT = DB_FRAC_BITS - 5;
    localparam int GQ_W       = TOT_W - GRIT_SHIFT;
    localparam int DIV3_SH    = 17;
    localparam logic [DIV3_SH-1:0] DIV3_MUL = DIV3_SH'(43691);

    // db to log2 conversion
    localparam int K_W = 30;
    localparam logic [K_W-1:0] LOG2_PER_DB_Q32 = K_W'(713378627);
    localparam int LOG_PROD_W = ATT_W + K_W;
    localparam int X_W = 20;
    localparam int U_W = 16;
    localparam int IP_W = X_W - U_W;

    // exp2 polynomial
    localparam int P_W = 32;
    localparam int POLY_IDX_W = 3;
    localparam logic [POLY_IDX_W-1:0] POLY_TOP  = 3'd5;
    localparam logic [POLY_IDX_W-1:0] POLY_LAST = 3'd4;

    // final scaling
    localparam int SH_W  = 6;
    localparam int RND_W = 40;
    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1 << AMP_FRAC_BITS);

    typedef struct packed {
        logic              gate;
        logic [ATT_W-1:0]  am_attenuation;
    } item_t;

    typedef struct packed {
        logic [AMP_W-1:0]   amplitude;
        logic [ATT_W-1:0]   env_attenuation;
        logic [STAGE_W-1:0] env_stage;
    } result_t;

    typedef struct packed {
        logic [COEF_W-1:0]   attack_coef;
        logic [ATT_W-1:0]    decay1_step;
        logic [ATT_W-1:0]    decay1_level;
        logic [ATT_W-1:0]    decay2_step;
        logic [ATT_W-1:0]    release_step;
        logic [STATIC_W-1:0] static_attenuation;
        logic                am_enable;
        logic                grit_mode;
    } cfg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                  load_item;
        logic                  env_update;
        logic                  sum_total;
        logic                  quantize;
        logic                  log_mul;
        logic                  poly_step;
        logic [POLY_IDX_W-1:0] poly_index;
        logic                  result_load;
    } cmd_t;

    // 2^u polynomial coefficients, Q.30
    function automatic logic [P_W-1:0] poly_coef(input logic [POLY_IDX_W-1:0] idx);
        logic [P_W-1:0] c;
        unique case (idx)
            3'd0:    c = P_W'(1073741642);
            3'd1:    c = P_W'(744269235);
            3'd2:    c = P_W'(257855341);
            3'd3:    c = P_W'(59953416);
            3'd4:    c = P_W'(9649997);
            3'd5:    c = P_W'(2013674);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/fmenv_cfg.sv
// configuration register bank for the fm operator envelope
// depends on fmenv_pkg
module fmenv_cfg
    import fmenv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ATTACK_COEF:  cfg_next.attack_coef        = cfg_data[COEF_W-1:0];
                CFG_DECAY1_STEP:  cfg_next.decay1_step        = cfg_data[ATT_W-1:0];
                CFG_DECAY1_LEVEL: cfg_next.decay1_level       = cfg_data[ATT_W-1:0];
                CFG_DECAY2_STEP:  cfg_next.decay2_step        = cfg_data[ATT_W-1:0];
                CFG_RELEASE_STEP: cfg_next.release_step       = cfg_data[ATT_W-1:0];
                CFG_STATIC_ATT:   cfg_next.static_attenuation = cfg_data[STATIC_W-1:0];
                CFG_AM_ENABLE:    cfg_next.am_enable          = cfg_data[0];
                CFG_GRIT_MODE:    cfg_next.grit_mode          = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_coef        <= COEF_ONE;
            cfg_reg.decay1_step        <= '0;
            cfg_reg.decay1_level       <= '0;
            cfg_reg.decay2_step        <= '0;
            cfg_reg.release_step       <= SILENT_DB;
            cfg_reg.static_attenuation <= '0;
            cfg_reg.am_enable          <= 1'b0;
            cfg_reg.grit_mode          <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/fmenv_dp.sv
// datapath: envelope state, total attenuation, db to linear gain, result word
// depends on fmenv_pkg; sequenced by fmenv_ctrl through cmd_t
module fmenv_dp
    import fmenv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    // envelope state
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [ATT_W-1:0]   att_reg, att_next;
    logic               prev_gate_reg;

    // per-word working registers
    logic               gate_reg;
    logic [ATT_W-1:0]   am_reg;
    logic [TOT_W-1:0]   total_reg;
    logic               silent_reg;
    logic [X_W-1:0]     x_reg;
    logic [P_W-1:0]     p_reg;
    result_t            result_reg;

    // envelope step
    logic                      key_on;
    logic [STAGE_W-1:0]        stage_gate;
    logic [COEF_W-1:0]         coef_w;
    logic [ATT_W+COEF_W-1:0]   attack_prod;
    logic [ATT_W-1:0]          attack_att;
    logic [ATT_W-1:0]          level_w;
    logic [ATT_W-1:0]          step_w;
    logic [ATT_W-1:0]          limit_w;
    logic [STAGE_W-1:0]        done_stage;
    logic [ATT_W:0]            grow;

    always_comb
    begin
        key_on     = gate_reg & ~prev_gate_reg;
        stage_gate = stage_reg;
        if (gate_reg && (key_on || stage_reg == ENV_IDLE))
            stage_gate = ENV_ATTACK;
        else if (!gate_reg && stage_reg != ENV_IDLE && stage_reg != ENV_RELEASE)
            stage_gate = ENV_RELEASE;

        coef_w = (cfg.attack_coef > COEF_ONE) ? COEF_ONE : cfg.attack_coef;
        attack_prod = (ATT_W+COEF_W)'(att_reg) * (ATT_W+COEF_W)'(coef_w);
        // coef is at most one, so the removed share never exceeds att_reg
        attack_att  = att_reg - attack_prod[ATT_W+15:16];

        level_w = (cfg.decay1_level > SILENT_DB) ? SILENT_DB : cfg.decay1_level;

        step_w     = '0;
        limit_w    = SILENT_DB;
        done_stage = stage_gate;
        case (stage_gate)
            ENV_DECAY1:
            begin
                step_w     = cfg.decay1_step;
                limit_w    = level_w;
                done_stage = ENV_DECAY2;
            end
            ENV_DECAY2:
            begin
                step_w     = cfg.decay2_step;
                done_stage = ENV_HOLD;
            end
            ENV_RELEASE:
            begin
                step_w     = cfg.release_step;
                done_stage = ENV_IDLE;
            end
            default: ;
        endcase
        grow = {1'b0, att_reg} + {1'b0, step_w};

        att_next   = att_reg;
        stage_next = stage_gate;
        case (stage_gate) inside
            ENV_ATTACK:
            begin
                // exponential approach, snaps to zero just above 0 dB
                if (attack_att < SNAP_DB)
                begin
                    att_next   = '0;
                    stage_next = ENV_DECAY1;
                end
                else
                begin
                    att_next = attack_att;
                end
            end
            ENV_DECAY1, ENV_DECAY2, ENV_RELEASE:
            begin
                if (grow >= {1'b0, limit_w})
                begin
                    att_next   = limit_w;
                    stage_next = done_stage;
                end
                else
                begin
                    att_next = grow[ATT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ENV_IDLE;
            att_reg       <= SILENT_DB;
            prev_gate_reg <= 1'b0;
        end
        else if (cmd.env_update)
        begin
            stage_reg     <= stage_next;
            att_reg       <= att_next;
            prev_gate_reg <= gate_reg;
        end
    end

    // total attenuation and grit quantization
    logic [TOT_W-1:0]         total_sum;
    logic [GQ_W-1:0]          gq_in;
    logic [GQ_W+DIV3_SH-1:0]  gq_prod;
    logic [GQ_W-1:0]          gq_quot;
    logic [GQ_W-1:0]          gq_times3;
    logic [TOT_W-1:0]         grit_total;

    always_comb
    begin
        total_sum = TOT_W'(att_reg) + TOT_W'(cfg.static_attenuation)
                  + (cfg.am_enable ? TOT_W'(am_reg) : TOT_W'(0));
        gq_in     = total_reg[TOT_W-1:GRIT_SHIFT];
        gq_prod   = (GQ_W+DIV3_SH)'(gq_in) * (GQ_W+DIV3_SH)'(DIV3_MUL);
        gq_quot   = gq_prod[GQ_W+DIV3_SH-1:DIV3_SH];
        gq_times3 = gq_quot + (gq_quot << 1);
        grit_total = {gq_times3, {GRIT_SHIFT{1'b0}}};
    end

    // db to log2, then 2^-x by horner steps on the fraction
    logic [LOG_PROD_W-1:0]  log_prod;
    logic [U_W-1:0]         u_w;
    logic [P_W+U_W-1:0]     poly_prod;
    logic [P_W-1:0]         poly_sum;

    always_comb
    begin
        log_prod  = LOG_PROD_W'(total_reg[ATT_W-1:0]) * LOG_PROD_W'(LOG2_PER_DB_Q32);
        // 1 - frac, zero when the fraction is zero
        u_w       = U_W'(0) - x_reg[U_W-1:0];
        poly_prod = (P_W+U_W)'(p_reg) * (P_W+U_W)'(u_w);
        poly_sum  = poly_coef(cmd.poly_index) + poly_prod[P_W+U_W-1:U_W];
    end

    // final shift with rounding and cap
    logic [IP_W:0]      s_w;
    logic [SH_W-1:0]    sh_w;
    logic [RND_W-1:0]   rnd_sum;
    logic [RND_W-1:0]   amp_full;
    logic [AMP_W-1:0]   amp_w;

    always_comb
    begin
        s_w      = {1'b0, x_reg[X_W-1:U_W]} + (IP_W+1)'(|x_reg[U_W-1:0]);
        sh_w     = SH_W'(30 - AMP_FRAC_BITS) + SH_W'(s_w);
        rnd_sum  = RND_W'(p_reg) + (RND_W'(1) << (sh_w - SH_W'(1)));
        amp_full = rnd_sum >> sh_w;
        if (silent_reg)
            amp_w = '0;
        else if (amp_full > RND_W'(AMP_ONE))
            amp_w = AMP_ONE;
        else
            amp_w = amp_full[AMP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            gate_reg <= item.gate;
            am_reg   <= item.am_attenuation;
        end
        if (cmd.sum_total)
            total_reg <= total_sum;
        else if (cmd.quantize && cfg.grit_mode)
            total_reg <= grit_total;
        if (cmd.log_mul)
        begin
            silent_reg <= (total_reg >= TOT_W'(SILENT_DB))
                       || (cfg.static_attenuation >= LIVE_LIMIT_DB);
            x_reg      <= log_prod[DB_FRAC_BITS+16+X_W-1:DB_FRAC_BITS+16];
            p_reg      <= poly_coef(POLY_TOP);
        end
        else if (cmd.poly_step)
        begin
            p_reg <= poly_sum;
        end
        if (cmd.result_load)
        begin
            result_reg.amplitude       <= amp_w;
            result_reg.env_attenuation <= att_reg;
            result_reg.env_stage       <= stage_reg;
        end
    end

    assign result = result_reg;

endmodule

FILE: hdl/fmenv_ctrl.sv
// controller: sequences one word through the datapath and owns both handshakes
// depends on fmenv_pkg; drives fmenv_dp through cmd_t
module fmenv_ctrl
    import fmenv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    output logic result_valid,
    input  logic result_stall,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ENV  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_GRIT = 7'b0001000,
        S_LOG  = 7'b0010000,
        S_POLY = 7'b0100000,
        S_AMP  = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t           state_reg, state_next;
    logic [POLY_IDX_W-1:0] poly_cnt_reg, poly_cnt_next;
    logic                  result_valid_reg, result_valid_next;
    logic                  out_free;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next        = state_reg;
        poly_cnt_next     = poly_cnt_reg;
        result_valid_next = result_valid_reg & result_stall;
        cmd               = '0;
        cmd.poly_index    = poly_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ENV;
                end
            end
            S_ENV:
            begin
                cmd.env_update = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_total = 1'b1;
                state_next    = S_GRIT;
            end
            S_GRIT:
            begin
                cmd.quantize = 1'b1;
                state_next   = S_LOG;
            end
            S_LOG:
            begin
                cmd.log_mul   = 1'b1;
                poly_cnt_next = POLY_LAST;
                state_next    = S_POLY;
            end
            S_POLY:
            begin
                cmd.poly_step = 1'b1;
                if (poly_cnt_reg == '0)
                    state_next = S_AMP;
                else
                    poly_cnt_next = poly_cnt_reg - POLY_IDX_W'(1);
            end
            S_AMP:
            begin
                // previous word must be gone before the output register reloads
                if (out_free)
                begin
                    cmd.result_load   = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            poly_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            poly_cnt_reg     <= poly_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!result_valid_reg || !result_stall))
        else $error("output register reloaded while a word is still held");

    a_accept_starts_env: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_ENV))
        else $error("accepted word did not start the envelope step");

    a_poly_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POLY) |-> (poly_cnt_reg <= POLY_LAST))
        else $error("polynomial step index out of range");

    a_valid_from_amp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_AMP))
        else $error("result raised outside the final step");

endmodule

FILE: hdl/fm_operator_envelope_db.sv
// fm operator envelope generator in db, with db to linear gain conversion
// depends on fmenv_pkg, fmenv_cfg, fmenv_ctrl, fmenv_dp
//
// usage:
// one input word per audio sample tick: item.gate and item.am_attenuation,
// taken at a clock edge with item_valid high and item_stall low.
// one result word per input word: amplitude, env_attenuation, env_stage,
// offered on result with result_valid and held while result_stall is high.
// configuration is written with cfg_write, cfg_index and cfg_data while the
// block is idle; indexes beyond the register list are ignored.
// sequence: a word is handled in order by envelope step, total, grit,
// log conversion, five horner steps of one shared 32x16 multiplier, final
// shift; its result is loaded into the output register at the final shift,
// and the next word is taken only after the block has returned to idle.
// the output register lets the next word be accepted and worked on while the
// previous result waits; if the receiver still stalls when that word is
// done, the block holds it and stalls the input until the result is taken.
// reset: envelope idle at 96 dB, key released, registers at defaults, no
// result pending.
module fm_operator_envelope_db
    import fmenv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    cmd_t cmd;

    fmenv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fmenv_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    fmenv_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

FILE: verif/fm_operator_envelope_db_chk.sv
// checker for fm_operator_envelope_db: watches the item, result and config ports,
// predicts each result word from its own envelope and gain model and compares them
// depends on fmenv_pkg only
module fm_operator_envelope_db_chk
    import fmenv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    failures
);

    localparam int COEF_FRAC = 16;
    localparam longint unsigned GRIT_DB = (3 * (1 << DB_FRAC_BITS)) >> 5;

    // register copies
    logic [COEF_W-1:0]   set_coef;
    logic [ATT_W-1:0]    set_d1_step;
    logic [ATT_W-1:0]    set_d1_level;
    logic [ATT_W-1:0]    set_d2_step;
    logic [ATT_W-1:0]    set_rel_step;
    logic [STATIC_W-1:0] set_static;
    logic                set_am_en;
    logic                set_grit;

    // envelope state
    logic [STAGE_W-1:0]  stage_q;
    logic [ATT_W-1:0]    att_q;
    logic                key_q;

    result_t due_words[$];
    int      err_cnt;

    // db attenuation to linear gain, 2^(-x) with x in log2 units
    function automatic logic [AMP_W-1:0] linear_gain(input logic [63:0] tot);
        logic [63:0] x, ip, fp, s, u, p, sh, amp;
        if (tot >= 64'(SILENT_DB) || set_static >= LIVE_LIMIT_DB)
            return '0;
        x  = (tot * 64'(LOG2_PER_DB_Q32)) >> (DB_FRAC_BITS + 16);
        ip = x >> 16;
        fp = x & 64'hFFFF;
        s  = ip + ((fp != 0) ? 64'd1 : 64'd0);
        u  = (fp != 0) ? ((64'd65536 - fp) << 14) : 64'd0;
        // horner in q.30
        p = 64'd2013674;
        p = 64'd9649997 + ((p * u) >> 30);
        p = 64'd59953416 + ((p * u) >> 30);
        p = 64'd257855341 + ((p * u) >> 30);
        p = 64'd744269235 + ((p * u) >> 30);
        p = 64'd1073741642 + ((p * u) >> 30);
        sh = 64'(30 - AMP_FRAC_BITS) + s;
        if (sh > 62)
            return '0;
        amp = (p + (64'd1 << (sh - 1))) >> sh;
        if (amp > 64'(AMP_ONE))
            amp = 64'(AMP_ONE);
        return amp[AMP_W-1:0];
    endfunction

    function automatic result_t envelope_tick(input item_t w);
        logic [63:0] a, coef, lvl, tot;
        logic        rise;
        result_t     r;
        a    = 64'(att_q);
        rise = w.gate && !key_q;
        key_q = w.gate;
        if (w.gate && (rise || stage_q == ENV_IDLE))
            stage_q = ENV_ATTACK;
        else if (!w.gate && stage_q != ENV_IDLE && stage_q != ENV_RELEASE)
            stage_q = ENV_RELEASE;

        case (stage_q)
            ENV_ATTACK:
            begin
                coef = (set_coef > COEF_ONE) ? 64'(COEF_ONE) : 64'(set_coef);
                a = a - ((a * coef) >> COEF_FRAC);
                if (a < 64'(SNAP_DB))
                begin
                    a = 0;
                    stage_q = ENV_DECAY1;
                end
            end
            ENV_DECAY1:
            begin
                lvl = (set_d1_level > SILENT_DB) ? 64'(SILENT_DB) : 64'(set_d1_level);
                a = a + 64'(set_d1_step);
                if (a >= lvl)
                begin
                    a = lvl;
                    stage_q = ENV_DECAY2;
                end
            end
            ENV_DECAY2:
            begin
                a = a + 64'(set_d2_step);
                if (a >= 64'(SILENT_DB))
                begin
                    a = 64'(SILENT_DB);
                    stage_q = ENV_HOLD;
                end
            end
            ENV_RELEASE:
            begin
                a = a + 64'(set_rel_step);
                if (a >= 64'(SILENT_DB))
                begin
                    a = 64'(SILENT_DB);
                    stage_q = ENV_IDLE;
                end
            end
            default: ;
        endcase
        att_q = a[ATT_W-1:0];

        tot = 64'(att_q) + 64'(set_static) + (set_am_en ? 64'(w.am_attenuation) : 64'd0);
        if (set_grit)
            tot = tot - (tot % GRIT_DB);

        r.amplitude       = linear_gain(tot);
        r.env_attenuation = att_q;
        r.env_stage       = stage_q;
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            set_coef     = COEF_ONE;
            set_d1_step  = '0;
            set_d1_level = '0;
            set_d2_step  = '0;
            set_rel_step = SILENT_DB;
            set_static   = '0;
            set_am_en    = 1'b0;
            set_grit     = 1'b0;
            stage_q      = ENV_IDLE;
            att_q        = SILENT_DB;
            key_q        = 1'b0;
            due_words.delete();
            err_cnt      = 0;
            pending     <= 0;
            failures    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ATTACK_COEF:  set_coef     = cfg_data[COEF_W-1:0];
                    CFG_DECAY1_STEP:  set_d1_step  = cfg_data[ATT_W-1:0];
                    CFG_DECAY1_LEVEL: set_d1_level = cfg_data[ATT_W-1:0];
                    CFG_DECAY2_STEP:  set_d2_step  = cfg_data[ATT_W-1:0];
                    CFG_RELEASE_STEP: set_rel_step = cfg_data[ATT_W-1:0];
                    CFG_STATIC_ATT:   set_static   = cfg_data;
                    CFG_AM_ENABLE:    set_am_en    = cfg_data[0];
                    CFG_GRIT_MODE:    set_grit     = cfg_data[0];
                    default: ;
                endcase
            end

            if (result_valid && !result_stall)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word with nothing expected: amplitude %0d att %0d stage %0d",
                           result.amplitude, result.env_attenuation, result.env_stage);
                    err_cnt++;
                end
                else
                begin
                    want = due_words.pop_front();
                    compare_field("amplitude", want.amplitude, result.amplitude);
                    compare_field("env_attenuation", want.env_attenuation,
                                  result.env_attenuation);
                    compare_field("env_stage", want.env_stage, result.env_stage);
                end
            end

            if (item_valid && !item_stall)
                due_words.push_back(envelope_tick(item));

            pending  <= due_words.size();
            failures <= err_cnt;
        end
    end

endmodule

FILE: verif/fm_operator_envelope_db_tb.sv
// testbench top for fm_operator_envelope_db: clock, reset, register settings and
// gate/am stimulus with random idling; checking lives in fm_operator_envelope_db_chk
// depends on fmenv_pkg, the block and the checker
module fm_operator_envelope_db_tb;
    import fmenv_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending;
    int                    failures;
    logic                  calm = 1'b0;

    localparam logic [ATT_W-1:0]  ATT_MAX  = '1;
    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    localparam int                DB       = 1 << DB_FRAC_BITS;

    fm_operator_envelope_db DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fm_operator_envelope_db_chk gain_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .failures     (failures)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !calm && ($urandom_range(99) < 19);
    end

    function automatic cfg_t settings(input logic [COEF_W-1:0] coef,
                                      input logic [ATT_W-1:0] d1_step,
                                      input logic [ATT_W-1:0] d1_level,
                                      input logic [ATT_W-1:0] d2_step,
                                      input logic [ATT_W-1:0] rel_step,
                                      input logic [STATIC_W-1:0] stat,
                                      input logic am_en, input logic grit);
        cfg_t c;
        c.attack_coef        = coef;
        c.decay1_step        = d1_step;
        c.decay1_level       = d1_level;
        c.decay2_step        = d2_step;
        c.release_step       = rel_step;
        c.static_attenuation = stat;
        c.am_enable          = am_en;
        c.grit_mode          = grit;
        return c;
    endfunction

    function automatic logic [ATT_W-1:0] rand_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ATT_MAX;
            2:       return ATT_W'(1);
            default: return ATT_W'($urandom_range(1 << 13, 1 << 20));
        endcase
    endfunction

    function automatic logic [ATT_W-1:0] rand_am();
        case ($urandom_range(3))
            0:       return ATT_W'($urandom);
            1:       return '0;
            default: return ATT_W'($urandom_range(0, 12 * DB));
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        case ($urandom_range(7))
            0:       c.attack_coef = '0;
            1:       c.attack_coef = COEF_ONE;
            2:       c.attack_coef = COEF_W'($urandom_range(65537, 131071));
            default: c.attack_coef = COEF_W'($urandom_range(2000, 65535));
        endcase
        c.decay1_step  = rand_step();
        c.decay1_level = ($urandom_range(9) == 0) ? ATT_W'($urandom)
                                                  : ATT_W'($urandom_range(0, SILENT_DB));
        c.decay2_step  = rand_step();
        c.release_step = rand_step();
        c.static_attenuation = ($urandom_range(7) == 0)
            ? STATIC_W'($urandom_range(LIVE_LIMIT_DB, 24'hFFFFFF))
            : STATIC_W'($urandom_range(0, 40 * DB));
        c.am_enable = $urandom_range(1);
        c.grit_mode = $urandom_range(1);
        return c;
    endfunction

    // unused upper data bits carry junk, the block must mask them
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int width);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value | (CFG_DATA_W'($urandom) << width);
        @(posedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(CFG_ATTACK_COEF, CFG_DATA_W'(c.attack_coef), COEF_W);
        write_reg(CFG_DECAY1_STEP, CFG_DATA_W'(c.decay1_step), ATT_W);
        write_reg(CFG_DECAY1_LEVEL, CFG_DATA_W'(c.decay1_level), ATT_W);
        write_reg(CFG_DECAY2_STEP, CFG_DATA_W'(c.decay2_step), ATT_W);
        write_reg(CFG_RELEASE_STEP, CFG_DATA_W'(c.release_step), ATT_W);
        write_reg(CFG_STATIC_ATT, c.static_attenuation, STATIC_W);
        write_reg(CFG_AM_ENABLE, CFG_DATA_W'(c.am_enable), 1);
        write_reg(CFG_GRIT_MODE, CFG_DATA_W'(c.grit_mode), 1);
        // index past the register list must be ignored
        write_reg(CFG_GRIT_MODE + CFG_IDX_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom),
                  CFG_DATA_W);
        cfg_write <= 1'b0;
    endtask

    task automatic send_word(input logic g, input logic [ATT_W-1:0] am);
        item_t w;
        if (!calm && $urandom_range(99) < 19)
        begin
            item_valid <= 1'b0;
            item       <= item_t'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        w.gate           = g;
        w.am_attenuation = am;
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // sender holds off until every outstanding word is back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // key-on / key-off phrases with random content, plus some single random ticks
    task automatic play_notes(input int count, input bit mid_pause);
        int sent, len, i;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_word($urandom_range(1), rand_am());
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 40);
                for (i = 0; i < len; i++)
                    send_word(1'b1, rand_am());
                sent += len;
                len = $urandom_range(1, 25);
                for (i = 0; i < len; i++)
                    send_word(1'b0, rand_am());
                sent += len;
            end
            if (mid_pause && sent >= count / 2)
            begin
                drain();
                mid_pause = 1'b0;
            end
        end
    endtask

    initial
    begin
        int i, n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // instant attack, 1 db decay-1 steps to 6 db, fast decay-2 and release
        program_regs(settings(COEF_ONE, ATT_W'(DB), ATT_W'(6 * DB), ATT_W'(48 * DB),
                              SILENT_DB, '0, 1'b1, 1'b0));
        send_word(1'b0, '0);
        send_word(1'b1, '0);
        send_word(1'b1, ATT_MAX);
        for (i = 0; i < 6; i++)
            send_word(1'b1, ATT_W'(12 * DB));
        send_word(1'b1, '0);
        send_word(1'b1, '0);
        send_word(1'b1, '0);
        send_word(1'b0, '0);
        send_word(1'b1, '0);
        send_word(1'b0, '0);

        // coefficient above one, zero decay-2 and release steps, static at the
        // live limit, grit on
        drain();
        program_regs(settings(COEF_MAX, ATT_MAX, ATT_W'(30 * DB), '0, '0,
                              STATIC_W'(LIVE_LIMIT_DB), 1'b0, 1'b1));
        send_word(1'b1, '0);
        send_word(1'b1, '0);
        send_word(1'b1, '0);
        send_word(1'b0, '0);
        send_word(1'b0, ATT_MAX);
        send_word(1'b1, ATT_MAX);

        // zero attack coefficient, decay-1 level past 96 db, minimum release step
        drain();
        program_regs(settings('0, ATT_MAX, ATT_MAX, ATT_MAX, ATT_W'(1), '1, 1'b1, 1'b1));
        send_word(1'b1, '0);
        send_word(1'b1, '0);
        send_word(1'b1, '0);
        send_word(1'b0, '0);
        send_word(1'b1, '0);
        send_word(1'b1, ATT_MAX);
        send_word(1'b0, '0);

        for (n = 0; n < 12; n++)
        begin
            drain();
            program_regs(random_settings());
            calm = (n == 5);
            play_notes(90, n == 3);
        end
        calm = 1'b0;

        item_valid <= 1'b0;
        @(posedge clk);
        for (i = 0; i < 4000 && pending != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
